/* design/teq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package teq_pkg;

  localparam int unsigned HALF_DEPTH = 512;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned ACT_W      = 2;
  localparam int unsigned POS_W      = 10;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned IDX_W      = $clog2(HALF_DEPTH);
  localparam int unsigned CNT_W      = $clog2(HALF_DEPTH + 1);
  localparam int unsigned CMP_W      = (CNT_W + 1 > POS_W) ? CNT_W + 1 : POS_W;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_BACK  = 2'd0,
    ACT_PUSH_FRONT = 2'd1,
    ACT_PUSH_MID   = 2'd2,
    ACT_READ       = 2'd3
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } stat_t;

  // ring slot of the k-th entry after head; correct only while head + k stays below twice the depth
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                               input logic [CNT_W-1:0] k);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(head) + (CNT_W+1)'(k);
    if (sum >= (CNT_W+1)'(HALF_DEPTH)) begin
      sum = sum - (CNT_W+1)'(HALF_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] inc_idx(input logic [IDX_W-1:0] head);
    logic [IDX_W-1:0] res;
    if (head == IDX_W'(HALF_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = head + 1'b1;
    end
    return res;
  endfunction

  function automatic logic [IDX_W-1:0] dec_idx(input logic [IDX_W-1:0] head);
    logic [IDX_W-1:0] res;
    if (head == '0) begin
      res = IDX_W'(HALF_DEPTH - 1);
    end else begin
      res = head - 1'b1;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* design/teq_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface teq_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [31:0] value;
  logic [9:0]         position;

  modport source (output valid, action, value, position, input ready);
  modport sink   (input valid, action, value, position, output ready);
endinterface

`default_nettype wire

/* design/teq_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface teq_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] read_value;
  logic [1:0]         status;

  modport source (output valid, read_value, status, input ready);
  modport sink   (input valid, read_value, status, output ready);
endinterface

`default_nettype wire

/* design/teq_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module teq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  teq_pkg::stat_t stat_i,
  output logic          in_ready_o,
  output teq_pkg::cmd_t cmd_o
);
  import teq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_FIN
  } state_e;

  state_e state_q;
  logic   ready_q;

  assign in_ready_o   = ready_q;
  assign cmd_o.accept = in_valid_i && ready_q;
  // finish only once the output register can take the result
  assign cmd_o.commit = (state_q == S_FIN) && stat_i.out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (cmd_o.accept) begin
            state_q <= S_FIN;
            ready_q <= 1'b0;
          end
        end
        S_FIN: begin
          if (cmd_o.commit) begin
            state_q <= S_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/teq_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module teq_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  teq_pkg::cmd_t                    cmd_i,
  output teq_pkg::stat_t                   stat_o,
  input  logic [teq_pkg::ACT_W-1:0]        action_i,
  input  logic signed [teq_pkg::DATA_W-1:0] value_i,
  input  logic [teq_pkg::POS_W-1:0]        position_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [teq_pkg::DATA_W-1:0] read_value_o,
  output logic [teq_pkg::STAT_W-1:0]       status_o
);
  import teq_pkg::*;

  logic [DATA_W-1:0] front_mem [HALF_DEPTH];
  logic [DATA_W-1:0] back_mem  [HALF_DEPTH];

  logic [IDX_W-1:0] fh_q, fh_d, bh_q, bh_d;
  logic [CNT_W-1:0] f_q, f_d, b_q, b_d;

  action_e           act_q;
  logic [DATA_W-1:0] value_q;
  status_e           status_q;
  logic              sel_front_q;
  logic [DATA_W-1:0] rd_front_q, rd_back_q;

  logic              out_valid_q;
  logic [DATA_W-1:0] out_value_q;
  status_e           out_status_q;

  action_e           act_in;
  logic [CMP_W-1:0]  pos_ext, f_ext, total;
  logic              even, full, in_range, sel_front;
  status_e           status_in;
  logic [IDX_W-1:0]  front_raddr, back_raddr;

  logic              fw_en, bw_en;
  logic [IDX_W-1:0]  fw_addr, bw_addr;
  logic [DATA_W-1:0] fw_data, bw_data;
  logic [DATA_W-1:0] result;

  assign act_in    = action_e'(action_i);
  assign pos_ext   = CMP_W'(position_i);
  assign f_ext     = CMP_W'(f_q);
  assign total     = f_ext + CMP_W'(b_q);
  assign even      = (f_q == b_q);
  assign full      = (f_q == CNT_W'(HALF_DEPTH)) && (b_q == CNT_W'(HALF_DEPTH));
  assign in_range  = pos_ext < total;
  assign sel_front = pos_ext < f_ext;

  always_comb begin
    if (act_in == ACT_READ) begin
      status_in = in_range ? STAT_OK : STAT_RANGE;
    end else begin
      status_in = full ? STAT_FULL : STAT_OK;
    end
  end

  // a read looks up the addressed entry; a push looks up the element it may move
  always_comb begin
    if (act_in == ACT_READ) begin
      front_raddr = slot_of(fh_q, CNT_W'(position_i));
      back_raddr  = slot_of(bh_q, CNT_W'(pos_ext - f_ext));
    end else begin
      front_raddr = slot_of(fh_q, f_q - 1'b1);
      back_raddr  = bh_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      act_q       <= act_in;
      value_q     <= DATA_W'(value_i);
      status_q    <= status_in;
      sel_front_q <= sel_front;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rd_front_q <= front_mem[front_raddr];
    end
    if (fw_en) begin
      front_mem[fw_addr] <= fw_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rd_back_q <= back_mem[back_raddr];
    end
    if (bw_en) begin
      back_mem[bw_addr] <= bw_data;
    end
  end

  // write back and rebalance; the moved element was fetched in the accept cycle
  always_comb begin
    fw_en   = 1'b0;
    bw_en   = 1'b0;
    fw_addr = slot_of(fh_q, f_q);
    bw_addr = slot_of(bh_q, b_q);
    fw_data = value_q;
    bw_data = value_q;
    fh_d    = fh_q;
    bh_d    = bh_q;
    f_d     = f_q;
    b_d     = b_q;
    if (cmd_i.commit && (status_q == STAT_OK)) begin
      unique case (act_q)
        ACT_PUSH_BACK: begin
          if (even) begin
            fw_en = 1'b1;
            f_d   = f_q + 1'b1;
            if (b_q != '0) begin
              fw_data = rd_back_q;
              bw_en   = 1'b1;
              bh_d    = inc_idx(bh_q);
            end
          end else begin
            bw_en = 1'b1;
            b_d   = b_q + 1'b1;
          end
        end
        ACT_PUSH_FRONT: begin
          fw_en   = 1'b1;
          fw_addr = dec_idx(fh_q);
          fh_d    = dec_idx(fh_q);
          if (even) begin
            f_d = f_q + 1'b1;
          end else begin
            bw_en   = 1'b1;
            bw_addr = dec_idx(bh_q);
            bw_data = rd_front_q;
            bh_d    = dec_idx(bh_q);
            b_d     = b_q + 1'b1;
          end
        end
        ACT_PUSH_MID: begin
          if (even) begin
            fw_en = 1'b1;
            f_d   = f_q + 1'b1;
          end else begin
            bw_en   = 1'b1;
            bw_addr = dec_idx(bh_q);
            bh_d    = dec_idx(bh_q);
            b_d     = b_q + 1'b1;
          end
        end
        ACT_READ: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fh_q <= '0;
      bh_q <= '0;
      f_q  <= '0;
      b_q  <= '0;
    end else begin
      fh_q <= fh_d;
      bh_q <= bh_d;
      f_q  <= f_d;
      b_q  <= b_d;
    end
  end

  always_comb begin
    if ((act_q == ACT_READ) && (status_q == STAT_OK)) begin
      result = sel_front_q ? rd_front_q : rd_back_q;
    end else begin
      result = '0;
    end
  end

  // output register: hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_value_q  <= result;
      out_status_q <= status_q;
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign read_value_o    = out_value_q;
  assign status_o        = out_status_q;

endmodule

`default_nettype wire

/* design/three_ended_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  Port    Direction  Payload
// request  req_i   in         action[1:0], value[31:0] signed, position[9:0]
// result   rsp_o   out        read_value[31:0] signed, status[1:0]
//
// The accept cycle reads both ring memories; once the output register is free,
// S_FIN writes back through their single write ports and loads the result.
// Reset clears ring heads and counts; the ring memories themselves are not cleared.
// A result waits in the output register while the next request is accepted;
// that request then holds in S_FIN until the output register frees.

module three_ended_queue (
  input  logic       clk_i,
  input  logic       rst_ni,
  teq_req_if.sink    req_i,
  teq_rsp_if.source  rsp_o
);
  import teq_pkg::*;

  cmd_t cmd;
  stat_t stat;
  logic  in_ready;

  teq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .stat_i     (stat),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  teq_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .action_i     (req_i.action),
    .value_i      (req_i.value),
    .position_i   (req_i.position),
    .out_valid_o  (rsp_o.valid),
    .out_ready_i  (rsp_o.ready),
    .read_value_o (rsp_o.read_value),
    .status_o     (rsp_o.status)
  );

  assign req_i.ready = in_ready;

`ifndef SYNTHESIS
  a_accept_commit_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.accept && cmd.commit))
    else $error("accept and commit in the same cycle");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.accept |=> !req_i.ready)
    else $error("request taken while previous one in flight");

  a_result_after_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> rsp_o.valid)
    else $error("committed result not presented");

  a_error_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status != STAT_OK)) |-> (rsp_o.read_value == '0))
    else $error("non-zero value on refused request");
`endif

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import teq_pkg::*;

  localparam int FRONT = 0;
  localparam int BACK  = 1;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_ITEMS = 1400;
  localparam int unsigned LONG_HOLD = 300;

  typedef struct {
    logic signed [DATA_W-1:0] read_value;
    logic [STAT_W-1:0]        status;
  } result_t;

  // Mirror of the two rings; predicts one result per request.
  class queue_scoreboard;
    logic [DATA_W-1:0] ring_mem [2][HALF_DEPTH];
    logic [IDX_W-1:0]  ring_head [2];
    logic [CNT_W-1:0]  ring_cnt [2];
    result_t           due_q [$];
    int unsigned       errors;

    function new();
      ring_head[FRONT] = '0;
      ring_head[BACK]  = '0;
      ring_cnt[FRONT]  = '0;
      ring_cnt[BACK]   = '0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return due_q.size();
    endfunction

    function logic [IDX_W-1:0] slot(int r, int unsigned k);
      return IDX_W'((int'(ring_head[r]) + k) % HALF_DEPTH);
    endfunction

    function void put_back(int r, logic [DATA_W-1:0] v);
      ring_mem[r][slot(r, ring_cnt[r])] = v;
      ring_cnt[r] = ring_cnt[r] + 1'b1;
    endfunction

    function void put_front(int r, logic [DATA_W-1:0] v);
      ring_head[r] = IDX_W'((int'(ring_head[r]) + HALF_DEPTH - 1) % HALF_DEPTH);
      ring_mem[r][ring_head[r]] = v;
      ring_cnt[r] = ring_cnt[r] + 1'b1;
    endfunction

    function logic [DATA_W-1:0] take_front(int r);
      logic [DATA_W-1:0] v;
      v = ring_mem[r][ring_head[r]];
      ring_head[r] = IDX_W'((int'(ring_head[r]) + 1) % HALF_DEPTH);
      ring_cnt[r] = ring_cnt[r] - 1'b1;
      return v;
    endfunction

    function logic [DATA_W-1:0] take_back(int r);
      ring_cnt[r] = ring_cnt[r] - 1'b1;
      return ring_mem[r][slot(r, ring_cnt[r])];
    endfunction

    function void note_request(action_e act, logic [DATA_W-1:0] v, logic [POS_W-1:0] pos);
      result_t     res;
      int unsigned f;
      int unsigned b;
      f = ring_cnt[FRONT];
      b = ring_cnt[BACK];
      res.read_value = '0;
      res.status = STAT_OK;
      if (act == ACT_READ) begin
        if (int'(pos) >= f + b) begin
          res.status = STAT_RANGE;
        end else if (int'(pos) < f) begin
          res.read_value = ring_mem[FRONT][slot(FRONT, pos)];
        end else begin
          res.read_value = ring_mem[BACK][slot(BACK, int'(pos) - f)];
        end
      end else if (f >= HALF_DEPTH && b >= HALF_DEPTH) begin
        res.status = STAT_FULL;
      end else begin
        case (act)
          ACT_PUSH_BACK: begin
            if (f == b) begin
              if (b == 0) begin
                put_back(FRONT, v);
              end else begin
                put_back(FRONT, take_front(BACK));
                put_back(BACK, v);
              end
            end else begin
              put_back(BACK, v);
            end
          end
          ACT_PUSH_FRONT: begin
            // move the front tail over first so the front half never overflows
            if (f != b) begin
              put_front(BACK, take_back(FRONT));
            end
            put_front(FRONT, v);
          end
          default: begin
            if (f == b) begin
              put_back(FRONT, v);
            end else begin
              put_front(BACK, v);
            end
          end
        endcase
      end
      due_q = {due_q, res};
    endfunction

    function void check_result(logic signed [DATA_W-1:0] rv, logic [STAT_W-1:0] st);
      result_t exp;
      if (due_q.size() == 0) begin
        errors++;
        if (errors <= 50) begin
          $error("result with no request outstanding: read_value %0d status %0d", rv, st);
        end
      end else begin
        exp = due_q.pop_front();
        if (st !== exp.status) begin
          errors++;
          if (errors <= 50) begin
            $error("status: expected %0d, actual %0d", exp.status, st);
          end
        end
        if (rv !== exp.read_value) begin
          errors++;
          if (errors <= 50) begin
            $error("read_value: expected %0d, actual %0d", exp.read_value, rv);
          end
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   idle_on = 1'b1;
  bit   hold_long = 1'b0;
  int unsigned cycle_cnt = 0;

  queue_scoreboard sb = new();

  teq_req_if req_if ();
  teq_rsp_if rsp_if ();

  three_ended_queue u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // check the result before noting a request taken on the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        sb.check_result(rsp_if.read_value, rsp_if.status);
      end
      if (req_if.valid && req_if.ready) begin
        sb.note_request(action_e'(req_if.action), req_if.value, req_if.position);
      end
    end
  end

  // result side: random stall bursts, plus one long hold on request
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready = 1'b0;
      end else if (hold_long) begin
        hold_long = 1'b0;
        stall_left = LONG_HOLD - 1;
        rsp_if.ready = 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 18);
        rsp_if.ready = 1'b0;
      end else begin
        rsp_if.ready = 1'b1;
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAIL");
    $finish;
  end

  // entered and left at a falling edge; valid stays high into the next call
  task automatic send_request(logic [ACT_W-1:0] act, logic [DATA_W-1:0] val,
                              logic [POS_W-1:0] pos);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      req_if.valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    req_if.valid    = 1'b1;
    req_if.action   = act;
    req_if.value    = val;
    req_if.position = pos;
    do begin
      @(posedge clk_i);
    end while (!req_if.ready);
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned      total;
    int unsigned      n;
    logic [ACT_W-1:0] act;
    logic [DATA_W-1:0] val;
    logic [POS_W-1:0] pos;

    rst_ni = 1'b0;
    req_if.valid    = 1'b0;
    req_if.action   = '0;
    req_if.value    = '0;
    req_if.position = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty-queue reads, pushes of each kind with extreme values, then reads
    send_request(ACT_READ, '0, '0);
    send_request(ACT_READ, '0, 10'd1023);
    send_request(ACT_PUSH_BACK,  32'h7FFF_FFFF, 10'd1023);
    send_request(ACT_PUSH_FRONT, 32'h8000_0000, '0);
    send_request(ACT_PUSH_MID,   32'h0000_0000, 10'h155);
    send_request(ACT_PUSH_BACK,  32'hFFFF_FFFF, 10'h2AA);
    send_request(ACT_PUSH_FRONT, 32'h0000_0001, '0);
    send_request(ACT_PUSH_MID,   32'h5555_5555, '0);
    send_request(ACT_PUSH_BACK,  32'hAAAA_AAAA, '0);
    for (int i = 0; i < 7; i++) begin
      send_request(ACT_READ, '0, POS_W'(i));
    end
    send_request(ACT_READ, '0, 10'd7);
    send_request(ACT_READ, '0, 10'd1023);
    total = 7;

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 500) begin
        // drain completely before going on
        req_if.valid = 1'b0;
        while (sb.pending() != 0) @(posedge clk_i);
        @(negedge clk_i);
      end
      if (n == 800) begin
        hold_long = 1'b1;
      end
      if (n == 1200) begin
        idle_on = 1'b0;
      end

      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0: val = 32'h8000_0000;
          1: val = 32'h7FFF_FFFF;
          2: val = 32'h0000_0000;
          default: val = 32'hFFFF_FFFF;
        endcase
      end else begin
        val = $urandom;
      end

      if ($urandom_range(0, 99) < 20) begin
        act = ACT_READ;
        if (total > 0 && $urandom_range(0, 3) != 0) begin
          pos = POS_W'($urandom_range(0, total - 1));
        end else begin
          pos = POS_W'($urandom_range(0, 1023));
        end
      end else begin
        case ($urandom_range(0, 2))
          0: act = ACT_PUSH_BACK;
          1: act = ACT_PUSH_FRONT;
          default: act = ACT_PUSH_MID;
        endcase
        pos = POS_W'($urandom_range(0, 1023));
        if (total < 2 * HALF_DEPTH) begin
          total++;
        end
      end
      send_request(act, val, pos);
    end
    req_if.valid = 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
